// File: rtl/mcq_pkg.sv
// ---------------------------------------------------------------------------
// mcq_pkg
// Shared widths, codes, state and control types of the least-cost
// candidate queue.
// ---------------------------------------------------------------------------
`default_nettype none

package mcq_pkg;

   // default number of queue slots
   localparam int QUEUE_DEPTH_DEF = 64;

   // payload widths
   localparam int ID_W     = 16;
   localparam int COST_W   = 24;
   localparam int STATUS_W = 3;
   localparam int OCC_W    = 7;

   // request modes
   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_POP  = 1'b1;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_PUSHED  = 3'd0,
      STATUS_UPDATED = 3'd1,
      STATUS_FULL    = 3'd2,
      STATUS_POPPED  = 3'd3,
      STATUS_EMPTY   = 3'd4
   } status_type;

   // controller states
   typedef enum logic [2:0] {
      CTRL_IDLE,
      CTRL_SCAN,
      CTRL_SCAN_WAIT,
      CTRL_DECIDE,
      CTRL_SHIFT,
      CTRL_SHIFT_WAIT
   } ctrl_state_type;

   // controller to datapath commands
   typedef struct packed {
      logic       start;
      logic       rd_en;
      logic       rd_shift;
      logic       addr_inc;
      logic       addr_from_best;
      logic       wr_update;
      logic       wr_append;
      logic       count_inc;
      logic       count_dec;
      logic       rsp_load;
      status_type rsp_status;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic is_pop;
      logic empty;
      logic full;
      logic match;
      logic best_last;
      logic scan_last;
      logic shift_last;
   } stat_type;

endpackage

`default_nettype wire

// File: rtl/mcq_req_if.sv
// ---------------------------------------------------------------------------
// mcq_req_if
// Request channel: push or pop word with valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface mcq_req_if;
   logic                       valid;
   logic                       ready;
   logic                       mode;
   logic [mcq_pkg::ID_W-1:0]   entry_id;
   logic [mcq_pkg::COST_W-1:0] entry_cost;

   modport source (output valid, output mode, output entry_id, output entry_cost,
                   input ready);
   modport sink   (input valid, input mode, input entry_id, input entry_cost,
                   output ready);
endinterface

`default_nettype wire

// File: rtl/mcq_rsp_if.sv
// ---------------------------------------------------------------------------
// mcq_rsp_if
// Response channel: status, removed entry and occupancy with valid/ready.
// ---------------------------------------------------------------------------
`default_nettype none

interface mcq_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [mcq_pkg::STATUS_W-1:0] status;
   logic [mcq_pkg::ID_W-1:0]     popped_id;
   logic [mcq_pkg::COST_W-1:0]   popped_cost;
   logic [mcq_pkg::OCC_W-1:0]    occupancy;

   modport source (output valid, output status, output popped_id, output popped_cost,
                   output occupancy, input ready);
   modport sink   (input valid, input status, input popped_id, input popped_cost,
                   input occupancy, output ready);
endinterface

`default_nettype wire

// File: rtl/mcq_ram.sv
// ---------------------------------------------------------------------------
// mcq_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module mcq_ram #(
   parameter int WIDTH = mcq_pkg::ID_W + mcq_pkg::COST_W,
   parameter int DEPTH = mcq_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/mcq_ctrl.sv
// ---------------------------------------------------------------------------
// mcq_ctrl
// Sequencer of the candidate queue: scan, decision, compaction shift and
// response handshake.
// ---------------------------------------------------------------------------
`default_nettype none

module mcq_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   input  wire mcq_pkg::stat_type stat,
   output      mcq_pkg::cmd_type  cmd
);

   mcq_pkg::ctrl_state_type state_ff;
   mcq_pkg::ctrl_state_type state_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic                    rsp_free;

   // response register can take a new word
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mcq_pkg::CTRL_IDLE: begin
            if (req_valid) begin
               state_in = stat.empty ? mcq_pkg::CTRL_DECIDE : mcq_pkg::CTRL_SCAN;
            end
         end
         mcq_pkg::CTRL_SCAN: begin
            if (stat.scan_last) begin
               state_in = mcq_pkg::CTRL_SCAN_WAIT;
            end
         end
         mcq_pkg::CTRL_SCAN_WAIT: begin
            state_in = mcq_pkg::CTRL_DECIDE;
         end
         mcq_pkg::CTRL_DECIDE: begin
            if (rsp_free) begin
               if (stat.is_pop && !stat.empty && !stat.best_last) begin
                  state_in = mcq_pkg::CTRL_SHIFT;
               end else begin
                  state_in = mcq_pkg::CTRL_IDLE;
               end
            end
         end
         mcq_pkg::CTRL_SHIFT: begin
            if (stat.shift_last) begin
               state_in = mcq_pkg::CTRL_SHIFT_WAIT;
            end
         end
         mcq_pkg::CTRL_SHIFT_WAIT: begin
            state_in = mcq_pkg::CTRL_IDLE;
         end
         default: begin
            state_in = mcq_pkg::CTRL_IDLE;
         end
      endcase
   end

   // commands
   always_comb begin
      cmd            = '0;
      cmd.rsp_status = mcq_pkg::STATUS_EMPTY;
      req_ready      = 1'b0;
      case (state_ff)
         mcq_pkg::CTRL_IDLE: begin
            req_ready = 1'b1;
            cmd.start = req_valid;
         end
         mcq_pkg::CTRL_SCAN: begin
            cmd.rd_en    = 1'b1;
            cmd.addr_inc = 1'b1;
         end
         mcq_pkg::CTRL_DECIDE: begin
            if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               if (stat.is_pop) begin
                  if (stat.empty) begin
                     cmd.rsp_status = mcq_pkg::STATUS_EMPTY;
                  end else begin
                     cmd.rsp_status     = mcq_pkg::STATUS_POPPED;
                     cmd.count_dec      = 1'b1;
                     cmd.addr_from_best = !stat.best_last;
                  end
               end else if (stat.match) begin
                  cmd.rsp_status = mcq_pkg::STATUS_UPDATED;
                  cmd.wr_update  = 1'b1;
               end else if (stat.full) begin
                  cmd.rsp_status = mcq_pkg::STATUS_FULL;
               end else begin
                  cmd.rsp_status = mcq_pkg::STATUS_PUSHED;
                  cmd.wr_append  = 1'b1;
                  cmd.count_inc  = 1'b1;
               end
            end
         end
         mcq_pkg::CTRL_SHIFT: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_shift = 1'b1;
            cmd.addr_inc = 1'b1;
         end
         mcq_pkg::CTRL_SCAN_WAIT, mcq_pkg::CTRL_SHIFT_WAIT: begin
            cmd.rd_en = 1'b0;
         end
         default: begin
            cmd.rd_en = 1'b0;
         end
      endcase
   end

   // response valid flag
   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mcq_pkg::CTRL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: rtl/mcq_dpath.sv
// ---------------------------------------------------------------------------
// mcq_dpath
// Datapath of the candidate queue: slot RAM kept compact in push order,
// fill count, scan comparators, shift write-back and response register.
// ---------------------------------------------------------------------------
`default_nettype none

module mcq_dpath #(
   parameter int QUEUE_DEPTH = mcq_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_mode,
   input  wire logic [mcq_pkg::ID_W-1:0]     req_entry_id,
   input  wire logic [mcq_pkg::COST_W-1:0]   req_entry_cost,
   input  wire mcq_pkg::cmd_type             cmd,
   output      mcq_pkg::stat_type            stat,
   output      logic [mcq_pkg::STATUS_W-1:0] rsp_status,
   output      logic [mcq_pkg::ID_W-1:0]     rsp_popped_id,
   output      logic [mcq_pkg::COST_W-1:0]   rsp_popped_cost,
   output      logic [mcq_pkg::OCC_W-1:0]    rsp_occupancy
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int DW = mcq_pkg::ID_W + mcq_pkg::COST_W;

   // control registers
   logic [CW-1:0] count_ff, count_in;
   logic          rd_vld_ff;
   logic          rd_shift_ff;

   // item and scan registers
   logic                       mode_ff;
   logic [mcq_pkg::ID_W-1:0]   id_ff;
   logic [mcq_pkg::COST_W-1:0] cost_ff;
   logic [AW-1:0]              addr_ff, addr_in;
   logic [AW-1:0]              rd_idx_ff;
   logic                       match_ff, match_in;
   logic [AW-1:0]              match_idx_ff, match_idx_in;
   logic                       found_ff, found_in;
   logic [AW-1:0]              best_idx_ff, best_idx_in;
   logic [mcq_pkg::ID_W-1:0]   best_id_ff, best_id_in;
   logic [mcq_pkg::COST_W-1:0] best_cost_ff, best_cost_in;

   // response registers
   logic [mcq_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [mcq_pkg::ID_W-1:0]     rsp_id_ff;
   logic [mcq_pkg::COST_W-1:0]   rsp_cost_ff;
   logic [mcq_pkg::OCC_W-1:0]    rsp_occ_ff;

   // ram ports
   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   logic [DW-1:0]              wr_data;
   logic [DW-1:0]              rd_data;
   logic [mcq_pkg::ID_W-1:0]   rd_id;
   logic [mcq_pkg::COST_W-1:0] rd_cost;
   logic                       scan_vld;
   logic                       popped;

   mcq_ram #(
      .WIDTH (DW),
      .DEPTH (QUEUE_DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign rd_id    = rd_data[DW-1:mcq_pkg::COST_W];
   assign rd_cost  = rd_data[mcq_pkg::COST_W-1:0];
   assign scan_vld = rd_vld_ff && !rd_shift_ff;
   assign popped   = (cmd.rsp_status == mcq_pkg::STATUS_POPPED);

   // slot address counter
   always_comb begin
      addr_in = addr_ff;
      if (cmd.start) begin
         addr_in = '0;
      end else if (cmd.addr_from_best) begin
         addr_in = best_idx_ff + AW'(1);
      end else if (cmd.addr_inc) begin
         addr_in = addr_ff + AW'(1);
      end
   end

   // duplicate search and least-cost search, later slots win cost ties
   always_comb begin
      match_in     = match_ff;
      match_idx_in = match_idx_ff;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_id_in   = best_id_ff;
      best_cost_in = best_cost_ff;
      if (cmd.start) begin
         match_in = 1'b0;
         found_in = 1'b0;
      end else if (scan_vld) begin
         if (mode_ff == mcq_pkg::MODE_PUSH) begin
            if (rd_id == id_ff) begin
               match_in     = 1'b1;
               match_idx_in = rd_idx_ff;
            end
         end else if (!found_ff || rd_cost <= best_cost_ff) begin
            found_in     = 1'b1;
            best_idx_in  = rd_idx_ff;
            best_id_in   = rd_id;
            best_cost_in = rd_cost;
         end
      end
   end

   // ram write: shift down after a pop, cost update, or append
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr_ff;
      wr_data = {id_ff, cost_ff};
      if (rd_vld_ff && rd_shift_ff) begin
         wr_en   = 1'b1;
         wr_addr = rd_idx_ff - AW'(1);
         wr_data = rd_data;
      end else if (cmd.wr_update) begin
         wr_en   = 1'b1;
         wr_addr = match_idx_ff;
      end else if (cmd.wr_append) begin
         wr_en   = 1'b1;
         wr_addr = count_ff[AW-1:0];
      end
   end

   // fill count
   always_comb begin
      count_in = count_ff;
      if (cmd.count_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         rd_vld_ff <= cmd.rd_en;
      end
   end

   always_ff @(posedge clock) begin
      rd_shift_ff  <= cmd.rd_shift;
      rd_idx_ff    <= addr_ff;
      addr_ff      <= addr_in;
      match_ff     <= match_in;
      match_idx_ff <= match_idx_in;
      found_ff     <= found_in;
      best_idx_ff  <= best_idx_in;
      best_id_ff   <= best_id_in;
      best_cost_ff <= best_cost_in;
      if (cmd.start) begin
         mode_ff <= req_mode;
         id_ff   <= req_entry_id;
         cost_ff <= req_entry_cost;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_id_ff     <= popped ? best_id_ff : '0;
         rsp_cost_ff   <= popped ? best_cost_ff : '0;
         rsp_occ_ff    <= mcq_pkg::OCC_W'(count_in);
      end
   end

   // status towards the controller
   always_comb begin
      stat.is_pop     = (mode_ff == mcq_pkg::MODE_POP);
      stat.empty      = (count_ff == '0);
      stat.full       = (count_ff == CW'(QUEUE_DEPTH));
      stat.match      = match_ff;
      stat.best_last  = ((CW'(best_idx_ff) + CW'(1)) == count_ff);
      stat.scan_last  = (CW'(addr_ff) == (count_ff - CW'(1)));
      stat.shift_last = (CW'(addr_ff) == count_ff);
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_popped_id   = rsp_id_ff;
   assign rsp_popped_cost = rsp_cost_ff;
   assign rsp_occupancy   = rsp_occ_ff;

endmodule

`default_nettype wire

// File: rtl/min_cost_unsorted_priority_queue_core.sv
// ---------------------------------------------------------------------------
// min_cost_unsorted_priority_queue_core
// Least-cost candidate queue for a shortest-path search: push with
// duplicate cost update, pop of the cheapest (newest on ties) entry.
// ---------------------------------------------------------------------------
//  channel    dir  handshake      word
//  req_chan   in   valid/ready    mode, entry_id, entry_cost
//  rsp_chan   out  valid/ready    status, popped_id, popped_cost, occupancy
//
//  entries sit compact in one slot RAM, oldest at slot 0; the single read
//  port scans one slot per cycle over the N queued entries for a push or a
//  pop, and a pop then moves every entry behind the removed slot down by one
//  slot; an empty queue skips the scan.
//  reset clears the fill count and the control state; no RAM clearing pass.
//  one word is worked at a time; the response register holds its word until
//  taken, and the next word waits in its decision cycle while it is full.
// ---------------------------------------------------------------------------
`default_nettype none

module min_cost_unsorted_priority_queue_core #(
   parameter int QUEUE_DEPTH = mcq_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   mcq_req_if.sink   req_chan,
   mcq_rsp_if.source rsp_chan
);

   mcq_pkg::cmd_type  cmd;
   mcq_pkg::stat_type stat;

   // sequencer
   mcq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // slot storage and compare
   mcq_dpath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_mode        (req_chan.mode),
      .req_entry_id    (req_chan.entry_id),
      .req_entry_cost  (req_chan.entry_cost),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_status      (rsp_chan.status),
      .rsp_popped_id   (rsp_chan.popped_id),
      .rsp_popped_cost (rsp_chan.popped_cost),
      .rsp_occupancy   (rsp_chan.occupancy)
   );

   // fill count never moves both ways at once
   a_count_dir: assert property (@(posedge clock) disable iff (reset)
      !(cmd.count_inc && cmd.count_dec))
      else $error("count incremented and decremented together");

   // a cost update only follows a duplicate hit
   a_update_hit: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_update |-> (stat.match && !stat.is_pop))
      else $error("cost update without duplicate id");

   // removed entry fields are zero unless an entry was popped
   a_pop_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status != mcq_pkg::STATUS_POPPED)
      |-> (rsp_chan.popped_id == '0 && rsp_chan.popped_cost == '0))
      else $error("popped fields set on non-pop response");

   // a taken request leaves idle at once
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request taken while previous word in work");

endmodule

`default_nettype wire

// File: tb/tb_min_cost_unsorted_priority_queue_core.sv
// ---------------------------------------------------------------------------
// tb_min_cost_unsorted_priority_queue_core
// Self-checking bench for the least-cost candidate queue. A directed table
// covers empty pops, extremes, duplicate cost updates, ties, a full queue
// and its drain. Random push/pop traffic follows in phases of varied fill
// bias and idling on both channels. Every response word is compared against
// its typed table outcome or an in-bench candidate list kept in push order.
// ---------------------------------------------------------------------------

module tb_min_cost_unsorted_priority_queue_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH      = mcq_pkg::QUEUE_DEPTH_DEF;
   localparam int ID_BITS    = mcq_pkg::ID_W;
   localparam int COST_BITS  = mcq_pkg::COST_W;
   localparam int OCC_BITS   = mcq_pkg::OCC_W;
   localparam int CHUNKS     = 8;
   localparam int CHUNK_LEN  = 180;
   localparam int PUSH_BIAS [CHUNKS] = '{55, 80, 35, 70, 45, 85, 30, 60};

   // one response word as the queue should report it
   typedef struct {
      mcq_pkg::status_type   status;
      logic [ID_BITS-1:0]    popped_id;
      logic [COST_BITS-1:0]  popped_cost;
      logic [OCC_BITS-1:0]   occupancy;
   } outcome_type;

   // one queued candidate
   typedef struct {
      logic [ID_BITS-1:0]   id;
      logic [COST_BITS-1:0] cost;
   } candidate_type;

   // one row of the directed table
   typedef struct {
      logic                 mode;
      logic [ID_BITS-1:0]   id;
      logic [COST_BITS-1:0] cost;
      int                   reps;
      logic [ID_BITS-1:0]   id_step;
      logic [COST_BITS-1:0] cost_step;
      bit                   typed;
      outcome_type          outcome;
   } directed_row_type;

   logic clock;
   logic reset;

   mcq_req_if req_bus ();
   mcq_rsp_if rsp_bus ();

   min_cost_unsorted_priority_queue_core #(
      .QUEUE_DEPTH(DEPTH)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus)
   );

   // candidate list, oldest first, and outcomes still owed by the block
   candidate_type    queued_candidates[$];
   outcome_type      awaited_outcomes[$];
   directed_row_type directed_rows[$];

   int error_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int words_checked = 0;
   int peak_occupancy = 0;
   int status_seen [5] = '{0, 0, 0, 0, 0};

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // overall watchdog
   initial begin
      #40ms;
      $display("tb_min_cost_unsorted_priority_queue_core NOT OK");
      $finish;
   end

   // apply one word to the candidate list and return what the block must say
   function automatic outcome_type next_queue_outcome(input logic mode,
                                                      input logic [ID_BITS-1:0] id,
                                                      input logic [COST_BITS-1:0] cost);
      outcome_type   res;
      int            hit;
      int            best;
      candidate_type fresh;
      res.status      = mcq_pkg::STATUS_EMPTY;
      res.popped_id   = '0;
      res.popped_cost = '0;
      if (mode == mcq_pkg::MODE_PUSH) begin
         hit = -1;
         foreach (queued_candidates[i])
            if (queued_candidates[i].id == id) hit = i;
         if (hit >= 0) begin
            // duplicate id keeps its place, only the cost moves
            queued_candidates[hit].cost = cost;
            res.status = mcq_pkg::STATUS_UPDATED;
         end else if (queued_candidates.size() >= DEPTH) begin
            res.status = mcq_pkg::STATUS_FULL;
         end else begin
            fresh.id   = id;
            fresh.cost = cost;
            queued_candidates.push_back(fresh);
            res.status = mcq_pkg::STATUS_PUSHED;
         end
      end else begin
         // newest first with strict less-than, so ties go to the newest
         best = -1;
         for (int i = queued_candidates.size() - 1; i >= 0; i--)
            if (best < 0 || queued_candidates[i].cost < queued_candidates[best].cost)
               best = i;
         if (best >= 0) begin
            res.status      = mcq_pkg::STATUS_POPPED;
            res.popped_id   = queued_candidates[best].id;
            res.popped_cost = queued_candidates[best].cost;
            queued_candidates.delete(best);
         end
      end
      res.occupancy = OCC_BITS'(queued_candidates.size());
      return res;
   endfunction

   // table entry; the outcome fields count only when typed is set
   function automatic void add_row(input logic mode, input logic [ID_BITS-1:0] id,
                                   input logic [COST_BITS-1:0] cost, input int reps,
                                   input logic [ID_BITS-1:0] id_step,
                                   input logic [COST_BITS-1:0] cost_step, input bit typed,
                                   input mcq_pkg::status_type status,
                                   input logic [ID_BITS-1:0] pid,
                                   input logic [COST_BITS-1:0] pcost, input int occ);
      directed_row_type row;
      row.mode                = mode;
      row.id                  = id;
      row.cost                = cost;
      row.reps                = reps;
      row.id_step             = id_step;
      row.cost_step           = cost_step;
      row.typed               = typed;
      row.outcome.status      = status;
      row.outcome.popped_id   = pid;
      row.outcome.popped_cost = pcost;
      row.outcome.occupancy   = OCC_BITS'(occ);
      directed_rows.push_back(row);
   endfunction

   // offer one word, hold it until taken, then log what should come back
   task automatic send_word(input logic mode, input logic [ID_BITS-1:0] id,
                            input logic [COST_BITS-1:0] cost, input bit typed,
                            input outcome_type typed_outcome);
      outcome_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.mode       <= mode;
      req_bus.entry_id   <= id;
      req_bus.entry_cost <= cost;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = next_queue_outcome(mode, id, cost);
      awaited_outcomes.push_back(typed ? typed_outcome : predicted);
   endtask

   task automatic compare_field(input string field, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         error_count++;
      end
   endtask

   // response side: check every word taken, stall cycle by cycle
   initial begin
      outcome_type want;
      rsp_bus.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_outcomes.size() == 0) begin
               $display("%0t: unexpected word, status %0d id %0h cost %0h occupancy %0d",
                        $time, rsp_bus.status, rsp_bus.popped_id, rsp_bus.popped_cost,
                        rsp_bus.occupancy);
               error_count++;
            end else begin
               want = awaited_outcomes.pop_front();
               compare_field("status", want.status, rsp_bus.status);
               compare_field("popped_id", want.popped_id, rsp_bus.popped_id);
               compare_field("popped_cost", want.popped_cost, rsp_bus.popped_cost);
               compare_field("occupancy", want.occupancy, rsp_bus.occupancy);
            end
            words_checked++;
            if (rsp_bus.status <= mcq_pkg::STATUS_EMPTY) status_seen[rsp_bus.status]++;
            if (rsp_bus.occupancy > peak_occupancy) peak_occupancy = rsp_bus.occupancy;
         end
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // stimulus
   initial begin
      outcome_type          no_outcome;
      logic                 mode_v;
      logic [ID_BITS-1:0]   id_v;
      logic [ID_BITS-1:0]   id_mask;
      logic [COST_BITS-1:0] cost_v;
      int                   pick;

      no_outcome.status      = mcq_pkg::STATUS_EMPTY;
      no_outcome.popped_id   = '0;
      no_outcome.popped_cost = '0;
      no_outcome.occupancy   = '0;

      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.mode       <= mcq_pkg::MODE_PUSH;
      req_bus.entry_id   <= '0;
      req_bus.entry_cost <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty pop, extremes, duplicate update with a tie at zero
      add_row(mcq_pkg::MODE_POP, 16'h0000, 24'h000000, 1, 0, 0, 1,
              mcq_pkg::STATUS_EMPTY, 0, 0, 0);
      add_row(mcq_pkg::MODE_PUSH, 16'h0000, 24'h000000, 1, 0, 0, 1,
              mcq_pkg::STATUS_PUSHED, 0, 0, 1);
      add_row(mcq_pkg::MODE_PUSH, 16'hFFFF, 24'hFFFFFF, 1, 0, 0, 1,
              mcq_pkg::STATUS_PUSHED, 0, 0, 2);
      add_row(mcq_pkg::MODE_PUSH, 16'hFFFF, 24'h000000, 1, 0, 0, 1,
              mcq_pkg::STATUS_UPDATED, 0, 0, 2);
      add_row(mcq_pkg::MODE_POP, 16'hFFFF, 24'hFFFFFF, 1, 0, 0, 1,
              mcq_pkg::STATUS_POPPED, 16'hFFFF, 0, 1);
      add_row(mcq_pkg::MODE_POP, 16'h1234, 24'h123456, 1, 0, 0, 1,
              mcq_pkg::STATUS_POPPED, 0, 0, 0);
      add_row(mcq_pkg::MODE_POP, 16'h0000, 24'h000000, 1, 0, 0, 1,
              mcq_pkg::STATUS_EMPTY, 0, 0, 0);
      // fill to the brim, drop a new id, update a queued one while full, then pop and push again
      add_row(mcq_pkg::MODE_PUSH, 16'h5A00, 24'h001000, DEPTH, 1, 24'h030301, 0,
              mcq_pkg::STATUS_PUSHED, 0, 0, 0);
      add_row(mcq_pkg::MODE_PUSH, 16'hA5A5, 24'h000001, 1, 0, 0, 1,
              mcq_pkg::STATUS_FULL, 0, 0, DEPTH);
      add_row(mcq_pkg::MODE_PUSH, 16'h5A20, 24'h000000, 1, 0, 0, 1,
              mcq_pkg::STATUS_UPDATED, 0, 0, DEPTH);
      add_row(mcq_pkg::MODE_POP, 16'h0000, 24'h000000, 1, 0, 0, 0,
              mcq_pkg::STATUS_EMPTY, 0, 0, 0);
      add_row(mcq_pkg::MODE_PUSH, 16'hA5A5, 24'h000001, 1, 0, 0, 0,
              mcq_pkg::STATUS_EMPTY, 0, 0, 0);
      add_row(mcq_pkg::MODE_PUSH, 16'h5A21, 24'hFFFFFF, 1, 0, 0, 0,
              mcq_pkg::STATUS_EMPTY, 0, 0, 0);
      add_row(mcq_pkg::MODE_PUSH, 16'h5A3F, 24'h000001, 1, 0, 0, 0,
              mcq_pkg::STATUS_EMPTY, 0, 0, 0);
      // drain, then pop past empty
      add_row(mcq_pkg::MODE_POP, 16'h0000, 24'h000000, DEPTH, 0, 0, 0,
              mcq_pkg::STATUS_EMPTY, 0, 0, 0);
      add_row(mcq_pkg::MODE_POP, 16'hFFFF, 24'hFFFFFF, 1, 0, 0, 1,
              mcq_pkg::STATUS_EMPTY, 0, 0, 0);
      // equal costs: newest wins, an update keeps the old push order
      add_row(mcq_pkg::MODE_PUSH, 16'h1234, 24'h000007, 1, 0, 0, 0,
              mcq_pkg::STATUS_EMPTY, 0, 0, 0);
      add_row(mcq_pkg::MODE_PUSH, 16'h4321, 24'h000007, 1, 0, 0, 0,
              mcq_pkg::STATUS_EMPTY, 0, 0, 0);
      add_row(mcq_pkg::MODE_PUSH, 16'h2222, 24'h000007, 1, 0, 0, 0,
              mcq_pkg::STATUS_EMPTY, 0, 0, 0);
      add_row(mcq_pkg::MODE_POP, 16'h0000, 24'h000000, 1, 0, 0, 0,
              mcq_pkg::STATUS_EMPTY, 0, 0, 0);
      add_row(mcq_pkg::MODE_PUSH, 16'h1234, 24'h000007, 1, 0, 0, 0,
              mcq_pkg::STATUS_EMPTY, 0, 0, 0);
      add_row(mcq_pkg::MODE_POP, 16'h0000, 24'h000000, 3, 0, 0, 0,
              mcq_pkg::STATUS_EMPTY, 0, 0, 0);

      foreach (directed_rows[r])
         for (int k = 0; k < directed_rows[r].reps; k++)
            send_word(directed_rows[r].mode,
                      ID_BITS'(directed_rows[r].id + k * directed_rows[r].id_step),
                      COST_BITS'(directed_rows[r].cost + k * directed_rows[r].cost_step),
                      directed_rows[r].typed, directed_rows[r].outcome);

      // random traffic: small id pool for duplicates and full queues,
      // narrow costs for ties, fill bias and idling vary by phase
      for (int chunk = 0; chunk < CHUNKS; chunk++) begin
         case (chunk % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
            default: begin send_idle_pct = 8; recv_stall_pct = 8; end
         endcase
         id_mask = ID_BITS'($urandom);
         for (int n = 0; n < CHUNK_LEN; n++) begin
            mode_v = ($urandom_range(0, 99) < PUSH_BIAS[chunk]) ?
                     mcq_pkg::MODE_PUSH : mcq_pkg::MODE_POP;
            pick = $urandom_range(0, 99);
            if (pick < 85) id_v = ID_BITS'(id_mask ^ $urandom_range(0, 79));
            else id_v = ID_BITS'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 35) cost_v = COST_BITS'($urandom_range(0, 7));
            else if (pick < 80) cost_v = COST_BITS'($urandom);
            else if (pick < 90) cost_v = 24'hFFFFFF;
            else cost_v = 24'h000000;
            send_word(mode_v, id_v, cost_v, 0, no_outcome);
         end
         // after every second phase, hold off until the block has answered everything
         if (chunk % 2 == 1) begin
            req_bus.valid <= 1'b0;
            while (awaited_outcomes.size() != 0) @(posedge clock);
         end
      end

      req_bus.valid <= 1'b0;
      while (awaited_outcomes.size() != 0) @(posedge clock);
      repeat (4 * DEPTH) @(posedge clock);

      $display("run covered %0d response words: %0d pushed, %0d updated, %0d dropped full,",
               words_checked, status_seen[mcq_pkg::STATUS_PUSHED],
               status_seen[mcq_pkg::STATUS_UPDATED], status_seen[mcq_pkg::STATUS_FULL]);
      $display("  %0d popped, %0d empty pops, peak occupancy %0d, %0d mismatches",
               status_seen[mcq_pkg::STATUS_POPPED], status_seen[mcq_pkg::STATUS_EMPTY],
               peak_occupancy, error_count);
      if (error_count == 0) begin
         $display("tb_min_cost_unsorted_priority_queue_core OK");
      end else begin
         $display("tb_min_cost_unsorted_priority_queue_core NOT OK");
      end
      $finish;
   end

endmodule
